// ----- hdl/lrwm_pkg.sv -----
// Shared constants and types for the letter reachability word matcher.
// No dependencies; every other file imports this package.
package lrwm_pkg;

  localparam int ALPHABET_DEF = 26;
  localparam int KIND_W       = 2;
  localparam int LETTER_W     = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR    = 2'd0,
    KIND_EDGE     = 2'd1,
    KIND_PAIR     = 2'd2,
    KIND_MISMATCH = 2'd3
  } kind_t;

endpackage

// ----- hdl/lrwm_if.sv -----
// Valid/ready channel interfaces for the item and result streams.
// Depends on lrwm_pkg for field widths.
interface lrwm_in_if import lrwm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [LETTER_W-1:0] from_letter;
  logic [LETTER_W-1:0] to_letter;
  logic                last;

  modport source (output valid, kind, from_letter, to_letter, last, input ready);
  modport sink   (input valid, kind, from_letter, to_letter, last, output ready);
endinterface

interface lrwm_out_if ();
  logic valid;
  logic ready;
  logic answer;

  modport source (output valid, answer, input ready);
  modport sink   (input valid, answer, output ready);
endinterface

// ----- hdl/letter_reachability_word_matcher.sv -----
// Letter reachability word matcher: closure matrix in a row RAM, word flag in logic.
// Edge beat: target row read, then one RMW per row; ignored if a letter is out of range.
// Letter pair: answer registered in the cycle after accept. Clear and length
// mismatch complete at accept; mismatch answer is registered at accept.
// Reset: synchronous rst_n; row valid flops clear at once, so the matrix reads as
// identity immediately, no clearing pass. Depends on lrwm_pkg, lrwm_if, lrwm_rows.
module letter_reachability_word_matcher import lrwm_pkg::*; #(
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  lrwm_in_if.sink       in_ch,
  lrwm_out_if.source    out_ch
);

  localparam int IW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam logic [IW-1:0] LAST_ROW = IW'(ALPHABET - 1);

  typedef enum logic [1:0] {S_IDLE, S_QUERY, S_TARGET, S_SWEEP} state_t;

  state_t              state_r;
  logic                word_ok_r;
  logic                out_valid_r;
  logic                out_answer_r;
  logic [IW-1:0]       src_r;
  logic [IW-1:0]       to_r;
  logic                last_r;
  logic                in_range_r;
  logic [IW-1:0]       row_r;
  logic [ALPHABET-1:0] tgt_r;

  logic                accept;
  kind_t               kind;
  logic                pair_ok;
  logic                clear;
  logic [IW-1:0]       rd_addr;
  logic [ALPHABET-1:0] rd_row;
  logic                wr_en;
  logic [ALPHABET-1:0] wr_data;
  logic                hit;

  assign kind    = kind_t'(in_ch.kind);
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept  = in_ch.valid && in_ch.ready;
  assign pair_ok = (int'(in_ch.from_letter) < ALPHABET) && (int'(in_ch.to_letter) < ALPHABET);
  assign clear   = accept && (kind == KIND_CLEAR);

  assign out_ch.valid  = out_valid_r;
  assign out_ch.answer = out_answer_r;

  always_comb begin
    unique case (state_r)
      S_IDLE:   rd_addr = (kind == KIND_EDGE) ? IW'(in_ch.to_letter) : IW'(in_ch.from_letter);
      S_TARGET: rd_addr = '0;
      S_SWEEP:  rd_addr = (row_r == LAST_ROW) ? '0 : row_r + 1'b1;
      default:  rd_addr = '0;
    endcase
  end

  // rows that already reach the edge source pick up the target row
  assign wr_en   = (state_r == S_SWEEP) && rd_row[src_r];
  assign wr_data = rd_row | tgt_r;
  assign hit     = in_range_r && rd_row[to_r];

  lrwm_rows #(.ALPHABET(ALPHABET)) u_rows (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (clear),
    .rd_addr (rd_addr),
    .rd_row  (rd_row),
    .wr_en   (wr_en),
    .wr_addr (row_r),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      word_ok_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !(accept && (kind == KIND_MISMATCH))) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (kind)
              KIND_CLEAR: begin
                word_ok_r <= 1'b1;
              end
              KIND_EDGE: begin
                if (pair_ok) begin
                  state_r <= S_TARGET;
                end
              end
              KIND_PAIR: begin
                state_r <= S_QUERY;
              end
              KIND_MISMATCH: begin
                word_ok_r    <= 1'b1;
                out_valid_r  <= 1'b1;
                out_answer_r <= 1'b0;
              end
            endcase
          end
        end
        S_QUERY: begin
          state_r <= S_IDLE;
          if (last_r) begin
            out_valid_r  <= 1'b1;
            out_answer_r <= word_ok_r && hit;
            word_ok_r    <= 1'b1;
          end else begin
            word_ok_r <= word_ok_r && hit;
          end
        end
        S_TARGET: begin
          state_r <= S_SWEEP;
        end
        S_SWEEP: begin
          if (row_r == LAST_ROW) begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      src_r      <= IW'(in_ch.from_letter);
      to_r       <= IW'(in_ch.to_letter);
      last_r     <= in_ch.last;
      in_range_r <= pair_ok;
    end
    if (state_r == S_TARGET) begin
      tgt_r <= rd_row;
      row_r <= '0;
    end else if (state_r == S_SWEEP) begin
      row_r <= rd_addr;
    end
  end

endmodule

// ----- hdl/lrwm_rows.sv -----
// Reachability row store: one synchronous RAM of ALPHABET rows, registered read.
// Per-row valid flops make unwritten rows read as identity rows. Uses lrwm_pkg.
module lrwm_rows import lrwm_pkg::*; #(
  parameter int ALPHABET = ALPHABET_DEF,
  localparam int IW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clear,
  input  logic [IW-1:0]       rd_addr,
  output logic [ALPHABET-1:0] rd_row,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_addr,
  input  logic [ALPHABET-1:0] wr_data
);

  logic [ALPHABET-1:0] mem [ALPHABET];
  logic [ALPHABET-1:0] row_valid_r;
  logic [ALPHABET-1:0] rd_q_r;
  logic                rdv_q_r;
  logic [IW-1:0]       rd_addr_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r      <= mem[rd_addr];
    rdv_q_r     <= row_valid_r[rd_addr];
    rd_addr_q_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      row_valid_r <= '0;
    end else if (wr_en) begin
      row_valid_r[wr_addr] <= 1'b1;
    end
  end

  // a row never written since clear is the identity row
  assign rd_row = rdv_q_r ? rd_q_r
                          : ({{(ALPHABET-1){1'b0}}, 1'b1} << rd_addr_q_r);

endmodule

// ----- bench/tb_letter_reachability_word_matcher.sv -----
`timescale 1ns / 100ps
// Self-checking bench for letter_reachability_word_matcher: directed table, then random words
// and edges under several handshake phases. Depends on lrwm_pkg, lrwm_if and the RTL top.
module tb;
  import lrwm_pkg::*;

  localparam int LETTERS  = ALPHABET_DEF;
  localparam int HOLD_LEN = 300;
  localparam int N_DIR    = 25;
  localparam int PHASE_N  = 356;
  localparam int SETTLE   = 40;

  typedef struct packed {
    kind_t               kind;
    logic [LETTER_W-1:0] src;
    logic [LETTER_W-1:0] dst;
    logic                fin;
    bit                  pinned;
    bit                  ans;
  } dir_row_t;

  logic clk;
  logic rst_n;

  lrwm_in_if  in_ch ();
  lrwm_out_if out_ch ();

  letter_reachability_word_matcher uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // expected-answer pinning for directed rows, travels with the beat
  logic pinned_valid;
  logic pinned_answer;

  // closure model state
  logic [LETTERS-1:0] closure_rows [LETTERS];
  bit                 word_flag;
  bit                 answer_q [$];

  int err_count;
  int beats_sent;
  int answers_checked;
  int idle_pct;
  int stall_pct;
  bit hold_req;
  int hold_cnt;

  dir_row_t dir_tab [N_DIR];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("TIMEOUT at %0t, %0d answers still pending", $time, answer_q.size());
    $display("letter_reachability_word_matcher regression: fail");
    $finish;
  end

  task automatic flag_error(input string what);
    $display("ERROR %0t: %s", $time, what);
    err_count++;
  endtask

  function automatic void load_identity();
    for (int r = 0; r < LETTERS; r++) begin
      closure_rows[r] = '0;
      closure_rows[r][r] = 1'b1;
    end
    word_flag = 1'b1;
  endfunction

  task automatic closure_step(input kind_t k, input logic [LETTER_W-1:0] f,
                              input logic [LETTER_W-1:0] t, input logic l,
                              output bit emits, output bit ans);
    logic [LETTERS-1:0] tgt;
    bit hit;
    emits = 1'b0;
    ans   = 1'b0;
    case (k)
      KIND_CLEAR: begin
        load_identity();
      end
      KIND_EDGE: begin
        if (f < LETTERS && t < LETTERS) begin
          tgt = closure_rows[t];
          for (int r = 0; r < LETTERS; r++)
            if (closure_rows[r][f]) closure_rows[r] = closure_rows[r] | tgt;
        end
      end
      KIND_PAIR: begin
        hit = (f < LETTERS && t < LETTERS) ? closure_rows[f][t] : 1'b0;
        word_flag = word_flag & hit;
        if (l) begin
          emits = 1'b1;
          ans = word_flag;
          word_flag = 1'b1;
        end
      end
      default: begin
        emits = 1'b1;
        ans = 1'b0;
        word_flag = 1'b1;
      end
    endcase
  endtask

  // monitor: check result beats, then predict from the accepted input beat
  always @(posedge clk) begin
    bit emits;
    bit ans;
    if (!rst_n) begin
      load_identity();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (answer_q.size() == 0) begin
          flag_error($sformatf("unexpected answer %0b", out_ch.answer));
        end else begin
          if (out_ch.answer !== answer_q[0])
            flag_error($sformatf("answer %0b, expected %0b", out_ch.answer, answer_q[0]));
          void'(answer_q.pop_front());
          answers_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        closure_step(kind_t'(in_ch.kind), in_ch.from_letter, in_ch.to_letter,
                     in_ch.last, emits, ans);
        if (emits) answer_q = {answer_q, (pinned_valid ? pinned_answer : ans)};
      end
    end
  end

  // receiver: random stalls, plus one long hold-off counted here
  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_LEN) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic idle_gap();
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_beat(input kind_t k, input logic [LETTER_W-1:0] f,
                           input logic [LETTER_W-1:0] t, input logic l,
                           input bit pin_v, input bit pin_a);
    idle_gap();
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= k;
    in_ch.from_letter <= f;
    in_ch.to_letter   <= t;
    in_ch.last        <= l;
    pinned_valid      <= pin_v;
    pinned_answer     <= pin_a;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [LETTER_W-1:0] rand_letter();
    if ($urandom_range(0, 99) < 4) return LETTER_W'($urandom_range(LETTERS, 31));
    return LETTER_W'($urandom_range(0, LETTERS - 1));
  endfunction

  // mostly well-formed word: mostly reachable match letters so words can pass
  task automatic send_word();
    int len;
    int cand [$];
    logic [LETTER_W-1:0] q;
    logic [LETTER_W-1:0] m;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      q = rand_letter();
      if (q < LETTERS && $urandom_range(0, 99) < 75) begin
        cand.delete();
        for (int b = 0; b < LETTERS; b++)
          if (closure_rows[q][b]) cand = {cand, b};
        m = LETTER_W'(cand[$urandom_range(0, cand.size() - 1)]);
      end else begin
        m = rand_letter();
      end
      // a few words are cut short and run into the next item
      if (i < len - 1 && $urandom_range(0, 99) < 3) return;
      send_beat(KIND_PAIR, q, m, (i == len - 1), 1'b0, 1'b0);
    end
  endtask

  task automatic run_phase(input int n);
    int target;
    int r;
    target = beats_sent + n;
    while (beats_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 3)
        send_beat(KIND_CLEAR, LETTER_W'($urandom), LETTER_W'($urandom), 1'($urandom),
                  1'b0, 1'b0);
      else if (r < 30)
        send_beat(KIND_EDGE, rand_letter(), rand_letter(), 1'($urandom), 1'b0, 1'b0);
      else if (r < 36)
        send_beat(KIND_MISMATCH, LETTER_W'($urandom), LETTER_W'($urandom), 1'($urandom),
                  1'b0, 1'b0);
      else if (r < 44)
        send_beat(kind_t'($urandom_range(0, 3)), LETTER_W'($urandom), LETTER_W'($urandom),
                  1'($urandom), 1'b0, 1'b0);
      else
        send_word();
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_CLEAR;
    in_ch.from_letter = '0;
    in_ch.to_letter   = '0;
    in_ch.last        = 1'b0;
    out_ch.ready      = 1'b0;
    pinned_valid      = 1'b0;
    pinned_answer     = 1'b0;
    err_count         = 0;
    beats_sent        = 0;
    answers_checked   = 0;
    idle_pct          = 0;
    stall_pct         = 0;
    hold_req          = 1'b0;
    hold_cnt          = 0;

    dir_tab = '{
      '{KIND_PAIR,     5'd0,  5'd0,  1'b1, 1'b1, 1'b1},  // reflexive after reset
      '{KIND_PAIR,     5'd0,  5'd1,  1'b1, 1'b1, 1'b0},
      '{KIND_PAIR,     5'd25, 5'd25, 1'b1, 1'b1, 1'b1},
      '{KIND_MISMATCH, 5'd31, 5'd31, 1'b1, 1'b1, 1'b0},
      '{KIND_MISMATCH, 5'd0,  5'd0,  1'b0, 1'b1, 1'b0},
      '{KIND_EDGE,     5'd0,  5'd1,  1'b0, 1'b0, 1'b0},
      '{KIND_EDGE,     5'd1,  5'd25, 1'b1, 1'b0, 1'b0},  // last ignored on edges
      '{KIND_PAIR,     5'd0,  5'd25, 1'b1, 1'b0, 1'b0},  // chained reach
      '{KIND_PAIR,     5'd0,  5'd1,  1'b0, 1'b0, 1'b0},
      '{KIND_PAIR,     5'd25, 5'd0,  1'b1, 1'b0, 1'b0},
      '{KIND_PAIR,     5'd31, 5'd31, 1'b1, 1'b1, 1'b0},  // out of alphabet
      '{KIND_PAIR,     5'd26, 5'd0,  1'b1, 1'b1, 1'b0},
      '{KIND_EDGE,     5'd31, 5'd0,  1'b0, 1'b0, 1'b0},  // ignored edges
      '{KIND_EDGE,     5'd0,  5'd31, 1'b0, 1'b0, 1'b0},
      '{KIND_PAIR,     5'd0,  5'd0,  1'b0, 1'b0, 1'b0},
      '{KIND_MISMATCH, 5'd21, 5'd10, 1'b1, 1'b1, 1'b0},  // drops partial word
      '{KIND_PAIR,     5'd0,  5'd2,  1'b0, 1'b0, 1'b0},
      '{KIND_CLEAR,    5'd31, 5'd31, 1'b1, 1'b0, 1'b0},  // clear rearms word flag
      '{KIND_PAIR,     5'd0,  5'd0,  1'b1, 1'b1, 1'b1},
      '{KIND_PAIR,     5'd0,  5'd25, 1'b1, 1'b1, 1'b0},
      '{KIND_EDGE,     5'd25, 5'd0,  1'b1, 1'b0, 1'b0},
      '{KIND_EDGE,     5'd2,  5'd25, 1'b0, 1'b0, 1'b0},
      '{KIND_PAIR,     5'd2,  5'd0,  1'b0, 1'b0, 1'b0},
      '{KIND_PAIR,     5'd1,  5'd1,  1'b1, 1'b0, 1'b0},
      '{KIND_CLEAR,    5'd0,  5'd0,  1'b0, 1'b0, 1'b0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_beat(dir_tab[i].kind, dir_tab[i].src, dir_tab[i].dst, dir_tab[i].fin,
                dir_tab[i].pinned, dir_tab[i].ans);
    wait_drained();

    // phase 0: no idling, with the receiver hold-off up front
    hold_req = 1'b1;
    run_phase(PHASE_N);
    wait_drained();

    idle_pct = 74; stall_pct = 0;
    run_phase(PHASE_N);
    wait_drained();

    idle_pct = 0; stall_pct = 74;
    run_phase(PHASE_N);
    wait_drained();

    idle_pct = 30; stall_pct = 30;
    run_phase(PHASE_N);
    wait_drained();

    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d input beats and %0d checked answers: directed table, hold-off,",
             beats_sent, answers_checked);
    $display("and random edges/words under no-idle, sender-idle, receiver-stall, mixed phases");
    if (err_count == 0)
      $display("letter_reachability_word_matcher regression: pass");
    else
      $display("letter_reachability_word_matcher regression: fail");
    $finish;
  end

endmodule

// ----- letter_reachability_word_matcher.f -----
hdl/lrwm_pkg.sv
hdl/lrwm_if.sv
hdl/lrwm_rows.sv
hdl/letter_reachability_word_matcher.sv
bench/tb_letter_reachability_word_matcher.sv
